// ===== rtl/kcb_pkg.sv =====
// ----------------------------------------------------------------------------
// kcb_pkg: shared types and codes of the keyed counter bank
// Operation and status codes, payload structs, table entry layout and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kcb_pkg;

	localparam int SLOTS_DEF = 16;

	localparam logic [3:0] OP_TICK        = 4'd0;
	localparam logic [3:0] OP_ADD         = 4'd1;
	localparam logic [3:0] OP_DELETE      = 4'd2;
	localparam logic [3:0] OP_PAUSE       = 4'd3;
	localparam logic [3:0] OP_RESUME      = 4'd4;
	localparam logic [3:0] OP_RESTART     = 4'd5;
	localparam logic [3:0] OP_QUERY       = 4'd6;
	localparam logic [3:0] OP_PAUSE_ALL   = 4'd7;
	localparam logic [3:0] OP_RESUME_ALL  = 4'd8;
	localparam logic [3:0] OP_RESTART_ALL = 4'd9;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [3:0]  operation;
		logic [31:0] counter_key;
		logic [31:0] limit_value;
		logic        repeat_mode;
		logic        start_enabled;
	} kcb_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        counter_enabled;
		logic        counter_finished;
		logic [31:0] counter_count;
	} kcb_out_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] count;
		logic [31:0] limit;
		logic        rep;
		logic        en;
		logic        done;
	} kcb_entry_t;

	// controller to datapath
	typedef struct packed {
		logic boot;      // load run flag from its start value
		logic start;     // input transaction accepted
		logic rd_en;     // table read issued
		logic chk;       // read data of the previous issue is valid
		logic resolve;   // keyed sweep ended without a match
		logic out_load;  // move result into the output register
	} kcb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic run;
		logic hit;
	} kcb_sts_t;

	function automatic logic is_keyed(input logic [3:0] op);
		return (op >= OP_ADD) && (op <= OP_QUERY);
	endfunction

endpackage

// ===== rtl/keyed_counter_bank_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_counter_bank_unit: bank of keyed counters with a shared table
// Top level joining the sequencer and the datapath; configuration port
// holding the start value of the run flag.
// ----------------------------------------------------------------------------
// Pause all, resume all, unknown codes and a tick while stopped go straight
// to the result; a running tick and restart all sweep every slot; a keyed
// operation stops at its first matching slot and on a miss sweeps every slot,
// then resolves. The table is a single memory swept one slot per cycle.
// The next transaction is taken the cycle after the result register loads.
// Reset frees all slots and sets the run flag; in_ready stays low until the boot load of the run flag is done.
module keyed_counter_bank_unit #(
	parameter int SLOTS = kcb_pkg::SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  kcb_pkg::kcb_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output kcb_pkg::kcb_out_t out_data
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	kcb_pkg::kcb_cmd_t cmd;
	kcb_pkg::kcb_sts_t sts;
	logic [IDX_W-1:0]  rd_idx, chk_idx;

	assign cfg_ready = 1'b1;

	kcb_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (in_data.operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.chk_idx   (chk_idx)
	);

	kcb_dp #(.SLOTS(SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_wdata (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.chk_idx   (chk_idx),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/kcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcb_ctrl: sequencer of the keyed counter bank
// Accepts operations, walks the table one slot per cycle and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
module kcb_ctrl #(
	parameter int SLOTS = kcb_pkg::SLOTS_DEF,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [3:0]       op,
	output logic             out_valid,
	input  logic             out_ready,
	input  kcb_pkg::kcb_sts_t sts,
	output kcb_pkg::kcb_cmd_t cmd,
	output logic [IDX_W-1:0] rd_idx,
	output logic [IDX_W-1:0] chk_idx
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_SWEEP_ALL = 3'd1;
	localparam logic [2:0] S_SWEEP_KEY = 3'd2;
	localparam logic [2:0] S_RESOLVE   = 3'd3;
	localparam logic [2:0] S_FINISH    = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] issue_cnt_q;
	logic             chk_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             out_valid_q;
	logic             boot_q;
	logic             accept, sweep, rd_en, last_chk, out_load;

	assign in_ready = (state_q == S_IDLE) && !boot_q;
	assign accept   = in_valid && in_ready;
	assign sweep    = (state_q == S_SWEEP_ALL) || (state_q == S_SWEEP_KEY);
	assign rd_en    = sweep && (issue_cnt_q != CNT_W'(SLOTS));
	assign rd_idx   = issue_cnt_q[IDX_W-1:0];
	assign last_chk = chk_s1 && (chk_idx_s1 == IDX_W'(SLOTS - 1));
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign chk_idx   = chk_idx_s1;

	assign cmd.boot     = boot_q;
	assign cmd.start    = accept;
	assign cmd.rd_en    = rd_en;
	assign cmd.chk      = chk_s1;
	assign cmd.resolve  = (state_q == S_RESOLVE);
	assign cmd.out_load = out_load;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kcb_pkg::is_keyed(op)) begin
						state_d = S_SWEEP_KEY;
					end else if ((op == kcb_pkg::OP_RESTART_ALL) ||
							((op == kcb_pkg::OP_TICK) && sts.run)) begin
						state_d = S_SWEEP_ALL;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SWEEP_ALL: begin
				if (last_chk) state_d = S_FINISH;
			end
			S_SWEEP_KEY: begin
				// stop on the first match, the read in flight is dropped
				if (chk_s1 && sts.hit) state_d = S_FINISH;
				else if (last_chk) state_d = S_RESOLVE;
			end
			S_RESOLVE: state_d = S_FINISH;
			S_FINISH: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_cnt_q <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			boot_q      <= 1'b1;
		end else begin
			state_q <= state_d;
			boot_q  <= 1'b0;
			if (accept) issue_cnt_q <= '0;
			else if (rd_en) issue_cnt_q <= issue_cnt_q + CNT_W'(1);
			chk_s1 <= rd_en && ((state_d == S_SWEEP_ALL) || (state_d == S_SWEEP_KEY));
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx;
	end

`ifndef SYNTHESIS
	a_chk_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> $past(rd_en))
		else $error("check stage valid without a preceding read");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted transaction did not start work");

	a_hit_in_key_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hit |-> (state_q == S_SWEEP_KEY))
		else $error("key match reported outside a keyed sweep");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> !$past(out_load))
		else $error("output register overwritten while held");
`endif

endmodule

// ===== rtl/kcb_dp.sv =====
// ----------------------------------------------------------------------------
// kcb_dp: datapath of the keyed counter bank
// Counter table memory, used bits, run flag, read-modify-write logic for
// the sweep, result and output registers.
// ----------------------------------------------------------------------------
module kcb_dp #(
	parameter int SLOTS = kcb_pkg::SLOTS_DEF,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  kcb_pkg::kcb_in_t  in_data,
	input  kcb_pkg::kcb_cmd_t cmd,
	input  logic [IDX_W-1:0]  rd_idx,
	input  logic [IDX_W-1:0]  chk_idx,
	output kcb_pkg::kcb_sts_t sts,
	output kcb_pkg::kcb_out_t out_data
);

	kcb_pkg::kcb_entry_t mem_q [SLOTS];
	kcb_pkg::kcb_entry_t rd_q;
	kcb_pkg::kcb_in_t    cur_q;
	kcb_pkg::kcb_out_t   res_q, out_q;
	logic [SLOTS-1:0]    used_q;
	logic                run_at_start_q, run_flag_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;

	kcb_pkg::kcb_entry_t e, new_e, tick_e, wr_data;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic                chk_used, key_hit, add_free;
	logic [31:0]         cnt_inc;

	assign e        = rd_q;
	assign chk_used = used_q[chk_idx];
	assign key_hit  = cmd.chk && kcb_pkg::is_keyed(cur_q.operation) && chk_used &&
		(e.key == cur_q.counter_key);
	assign add_free = cmd.resolve && (cur_q.operation == kcb_pkg::OP_ADD) && free_found_q;

	assign sts.run  = run_flag_q;
	assign sts.hit  = key_hit;
	assign out_data = out_q;

	always_comb begin
		new_e.key   = cur_q.counter_key;
		new_e.count = 32'd0;
		new_e.limit = cur_q.limit_value;
		new_e.rep   = cur_q.repeat_mode;
		new_e.en    = cur_q.start_enabled;
		new_e.done  = 1'b0;
	end

	// a repeating counter drops its finished flag before it steps
	always_comb begin
		tick_e  = e;
		cnt_inc = e.count + 32'd1;
		tick_e.done = e.done && !e.rep;
		if (!tick_e.done) begin
			if (cnt_inc > e.limit) begin
				tick_e.done  = 1'b1;
				tick_e.count = 32'd0;
			end else begin
				tick_e.count = cnt_inc;
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = chk_idx;
		wr_data = e;
		if (cmd.chk) begin
			unique case (cur_q.operation)
				kcb_pkg::OP_TICK: begin
					wr_en   = chk_used && e.en;
					wr_data = tick_e;
				end
				kcb_pkg::OP_RESTART_ALL: begin
					wr_en         = chk_used;
					wr_data.count = 32'd0;
					wr_data.done  = 1'b0;
				end
				kcb_pkg::OP_ADD: begin
					wr_en   = key_hit;
					wr_data = new_e;
				end
				kcb_pkg::OP_PAUSE: begin
					wr_en      = key_hit;
					wr_data.en = 1'b0;
				end
				kcb_pkg::OP_RESUME: begin
					wr_en      = key_hit;
					wr_data.en = 1'b1;
				end
				kcb_pkg::OP_RESTART: begin
					wr_en         = key_hit;
					wr_data.count = 32'd0;
					wr_data.done  = 1'b0;
				end
				default: wr_en = 1'b0;
			endcase
		end else if (add_free) begin
			wr_en   = 1'b1;
			wr_idx  = free_idx_q;
			wr_data = new_e;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_idx] <= wr_data;
		if (cmd.rd_en) rd_q <= mem_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q         <= '0;
			run_at_start_q <= 1'b1;
			run_flag_q     <= 1'b1;
			free_found_q   <= 1'b0;
		end else begin
			if (cfg_we) run_at_start_q <= cfg_wdata;
			if (cmd.boot) begin
				run_flag_q <= run_at_start_q;
			end else if (cmd.start && (in_data.operation == kcb_pkg::OP_PAUSE_ALL)) begin
				run_flag_q <= 1'b0;
			end else if (cmd.start && (in_data.operation == kcb_pkg::OP_RESUME_ALL)) begin
				run_flag_q <= 1'b1;
			end
			if (key_hit && (cur_q.operation == kcb_pkg::OP_DELETE)) begin
				used_q[chk_idx] <= 1'b0;
			end else if (add_free) begin
				used_q[free_idx_q] <= 1'b1;
			end
			if (cmd.start) free_found_q <= 1'b0;
			else if (cmd.chk && !chk_used) free_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) cur_q <= in_data;
		// remember the lowest free slot seen so far
		if (cmd.chk && !chk_used && !free_found_q) free_idx_q <= chk_idx;
		if (cmd.start) begin
			res_q.status           <= kcb_pkg::ST_OK;
			res_q.counter_enabled  <= 1'b0;
			res_q.counter_finished <= 1'b0;
			res_q.counter_count    <= 32'd0;
		end else if (key_hit && (cur_q.operation == kcb_pkg::OP_QUERY)) begin
			res_q.counter_enabled  <= e.en;
			res_q.counter_finished <= e.done;
			res_q.counter_count    <= e.count;
		end else if (cmd.resolve) begin
			if (cur_q.operation != kcb_pkg::OP_ADD) res_q.status <= kcb_pkg::ST_MISSING;
			else if (!free_found_q) res_q.status <= kcb_pkg::ST_FULL;
		end
		if (cmd.out_load) out_q <= res_q;
	end

endmodule

// ===== verif/keyed_counter_bank_unit_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_counter_bank_unit_tb: self-checking bench for the keyed counter bank
// Sends a short table of directed operations, then random phases over a
// small pool of keys. A behavioral copy of the counter table predicts every
// untyped result; all are compared field by field in order. Both sides idle
// at random, and the bank is drained between phases for register writes.
// ----------------------------------------------------------------------------
module keyed_counter_bank_unit_tb;

	localparam int          SLOTS       = kcb_pkg::SLOTS_DEF;
	localparam int          KEY_POOL    = 24;
	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam logic [3:0]  OP_CODE_TOP = 4'hF;

	typedef struct {
		kcb_pkg::kcb_in_t  item;
		bit                typed;
		kcb_pkg::kcb_out_t want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_data;
	logic              in_valid;
	logic              in_ready;
	kcb_pkg::kcb_in_t  in_data;
	logic              out_valid;
	logic              out_ready;
	kcb_pkg::kcb_out_t out_data;

	// Typed expectation travelling with the item being offered
	bit                in_typed;
	kcb_pkg::kcb_out_t in_want;

	// Behavioral copy of the counter table
	logic        bank_used  [SLOTS];
	logic [31:0] bank_key   [SLOTS];
	logic [31:0] bank_count [SLOTS];
	logic [31:0] bank_limit [SLOTS];
	logic        bank_rep   [SLOTS];
	logic        bank_en    [SLOTS];
	logic        bank_done  [SLOTS];
	logic        bank_run;
	logic        start_run;

	kcb_pkg::kcb_out_t pending_results [$];
	dir_row_t          dir_tab [$];
	logic [31:0]       key_pool [KEY_POOL];
	bit                no_idle;
	int                fault_count;
	int                cycle_count;

	keyed_counter_bank_unit #(.SLOTS(SLOTS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Apply one operation to the table copy and return its result
	function automatic kcb_pkg::kcb_out_t bank_apply(kcb_pkg::kcb_in_t it);
		kcb_pkg::kcb_out_t r;
		int                hit;
		int                slot;
		r = '0;
		r.status = kcb_pkg::ST_OK;
		hit = -1;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (bank_used[i] && bank_key[i] == it.counter_key)
				hit = i;
		case (it.operation)
			kcb_pkg::OP_TICK: begin
				if (bank_run) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (bank_used[i] && bank_en[i]) begin
							if (bank_rep[i] && bank_done[i])
								bank_done[i] = 1'b0;
							if (!bank_done[i]) begin
								bank_count[i] = bank_count[i] + 32'd1;
								if (bank_count[i] > bank_limit[i]) begin
									bank_done[i]  = 1'b1;
									bank_count[i] = '0;
								end
							end
						end
					end
				end
			end
			kcb_pkg::OP_ADD: begin
				slot = hit;
				if (slot < 0)
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!bank_used[i])
							slot = i;
				if (slot < 0) begin
					r.status = kcb_pkg::ST_FULL;
				end else begin
					bank_used[slot]  = 1'b1;
					bank_key[slot]   = it.counter_key;
					bank_count[slot] = '0;
					bank_limit[slot] = it.limit_value;
					bank_done[slot]  = 1'b0;
					bank_rep[slot]   = it.repeat_mode;
					bank_en[slot]    = it.start_enabled;
				end
			end
			kcb_pkg::OP_DELETE, kcb_pkg::OP_PAUSE, kcb_pkg::OP_RESUME,
			kcb_pkg::OP_RESTART, kcb_pkg::OP_QUERY: begin
				if (hit < 0) begin
					r.status = kcb_pkg::ST_MISSING;
				end else begin
					case (it.operation)
						kcb_pkg::OP_DELETE:  bank_used[hit] = 1'b0;
						kcb_pkg::OP_PAUSE:   bank_en[hit] = 1'b0;
						kcb_pkg::OP_RESUME:  bank_en[hit] = 1'b1;
						kcb_pkg::OP_RESTART: begin
							bank_count[hit] = '0;
							bank_done[hit]  = 1'b0;
						end
						default: begin
							r.counter_enabled  = bank_en[hit];
							r.counter_finished = bank_done[hit];
							r.counter_count    = bank_count[hit];
						end
					endcase
				end
			end
			kcb_pkg::OP_PAUSE_ALL:  bank_run = 1'b0;
			kcb_pkg::OP_RESUME_ALL: bank_run = 1'b1;
			kcb_pkg::OP_RESTART_ALL: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (bank_used[i]) begin
						bank_count[i] = '0;
						bank_done[i]  = 1'b0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		kcb_pkg::kcb_out_t want_r;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want_r = bank_apply(in_data);
				if (in_typed)
					want_r = in_want;
				pending_results.push_back(want_r);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no expectation pending");
					fault_count++;
				end else begin
					want_r = pending_results.pop_front();
					if (out_data.status !== want_r.status) begin
						$error("status: expected %0d, got %0d", want_r.status, out_data.status);
						fault_count++;
					end
					if (out_data.counter_enabled !== want_r.counter_enabled) begin
						$error("counter_enabled: expected %0d, got %0d",
							want_r.counter_enabled, out_data.counter_enabled);
						fault_count++;
					end
					if (out_data.counter_finished !== want_r.counter_finished) begin
						$error("counter_finished: expected %0d, got %0d",
							want_r.counter_finished, out_data.counter_finished);
						fault_count++;
					end
					if (out_data.counter_count !== want_r.counter_count) begin
						$error("counter_count: expected %0h, got %0h",
							want_r.counter_count, out_data.counter_count);
						fault_count++;
					end
				end
			end
		end
	end

	// Result side: stall a random number of cycles before each transaction
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	function automatic dir_row_t tab_row(logic [3:0] op, logic [31:0] key, logic [31:0] lim,
			bit rep, bit en, bit typed, logic [1:0] st, bit qe, bit qd, logic [31:0] qc);
		dir_row_t row;
		row.item.operation      = op;
		row.item.counter_key    = key;
		row.item.limit_value    = lim;
		row.item.repeat_mode    = rep;
		row.item.start_enabled  = en;
		row.typed               = typed;
		row.want.status         = st;
		row.want.counter_enabled  = qe;
		row.want.counter_finished = qd;
		row.want.counter_count    = qc;
		return row;
	endfunction

	function automatic kcb_pkg::kcb_in_t rand_item(int pool_n, int add_pct);
		kcb_pkg::kcb_in_t it;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < add_pct) begin
			it.operation = kcb_pkg::OP_ADD;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 40)      it.operation = kcb_pkg::OP_TICK;
			else if (pick < 64) it.operation = kcb_pkg::OP_QUERY;
			else if (pick < 71) it.operation = kcb_pkg::OP_DELETE;
			else if (pick < 77) it.operation = kcb_pkg::OP_PAUSE;
			else if (pick < 84) it.operation = kcb_pkg::OP_RESUME;
			else if (pick < 89) it.operation = kcb_pkg::OP_RESTART;
			else if (pick < 91) it.operation = kcb_pkg::OP_PAUSE_ALL;
			else if (pick < 95) it.operation = kcb_pkg::OP_RESUME_ALL;
			else if (pick < 97) it.operation = kcb_pkg::OP_RESTART_ALL;
			else it.operation = 4'($urandom_range(kcb_pkg::OP_RESTART_ALL + 1, OP_CODE_TOP));
		end
		// mostly pooled keys so lookups hit; now and then a stray key
		it.counter_key = ($urandom_range(0, 9) == 0) ? $urandom
			: key_pool[$urandom_range(0, pool_n - 1)];
		case ($urandom_range(0, 9))
			7, 8:    it.limit_value = $urandom;
			9:       it.limit_value = ALL_ONES;
			default: it.limit_value = $urandom_range(0, 5);
		endcase
		it.repeat_mode   = 1'($urandom);
		it.start_enabled = 1'($urandom);
		return it;
	endfunction

	task automatic send_item(kcb_pkg::kcb_in_t item, bit typed, kcb_pkg::kcb_out_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		in_typed <= typed;
		in_want  <= want;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// Hold input until every pending result is back
	task automatic drain_bank();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		@(posedge clk);
	endtask

	task automatic load_run_start(logic value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		start_run = value;
	endtask

	task automatic run_phase(int count, int pool_n, int add_pct, bit stretches);
		for (int n = 0; n < count; n++) begin
			if (stretches && (n % 50) == 0)
				no_idle = !no_idle;
			send_item(rand_item(pool_n, add_pct), 1'b0, '0);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		in_typed    = 1'b0;
		in_want     = '0;
		out_ready   = 1'b0;
		no_idle     = 1'b0;
		fault_count = 0;
		cycle_count = 0;
		start_run   = 1'b1;

		for (int i = 0; i < SLOTS; i++) begin
			bank_used[i]  = 1'b0;
			bank_key[i]   = '0;
			bank_count[i] = '0;
			bank_limit[i] = '0;
			bank_rep[i]   = 1'b0;
			bank_en[i]    = 1'b0;
			bank_done[i]  = 1'b0;
		end
		bank_run = start_run;

		key_pool[0] = '0;
		key_pool[1] = ALL_ONES;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = $urandom;

		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_MISSING, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_DELETE, ALL_ONES, 32'd0, 0, 0,
			1, kcb_pkg::ST_MISSING, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_PAUSE, 32'd5, 32'd0, 0, 0,
			1, kcb_pkg::ST_MISSING, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_RESUME, 32'd5, 32'd0, 1, 1,
			1, kcb_pkg::ST_MISSING, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_TICK, ALL_ONES, ALL_ONES, 1, 1,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_ADD, 32'd0, 32'd0, 0, 1,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_ADD, ALL_ONES, ALL_ONES, 1, 1,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_TICK, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		// limit zero: the first step overshoots and finishes at count zero
		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 1, 1, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_TICK, 32'd0, 32'd0, 0, 0,
			0, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, 32'd0, 32'd0, 0, 0,
			0, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, ALL_ONES, 32'd0, 0, 0,
			0, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_PAUSE_ALL, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_TICK, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, ALL_ONES, 32'd0, 0, 0,
			0, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_RESUME_ALL, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		// overwrite an existing key: count and finished drop back
		dir_tab.push_back(tab_row(kcb_pkg::OP_ADD, 32'd0, 32'd1, 1, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_RESUME, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_TICK, 32'd0, 32'd0, 0, 0,
			0, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_TICK, 32'd0, 32'd0, 0, 0,
			0, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_TICK, 32'd0, 32'd0, 0, 0,
			0, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, 32'd0, 32'd0, 0, 0,
			0, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_PAUSE, ALL_ONES, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_RESTART_ALL, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, ALL_ONES, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(OP_CODE_TOP, ALL_ONES, ALL_ONES, 1, 1,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_RESTART_ALL + 4'd1, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_DELETE, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_OK, 0, 0, 0));
		dir_tab.push_back(tab_row(kcb_pkg::OP_QUERY, 32'd0, 32'd0, 0, 0,
			1, kcb_pkg::ST_MISSING, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// start value is only loaded by the boot step after reset, which has passed, so the bank keeps running
		load_run_start(1'b0);
		foreach (dir_tab[i])
			send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
		drain_bank();

		load_run_start(1'b1);
		run_phase(500, KEY_POOL, 35, 1'b0);
		drain_bank();

		load_run_start(1'b0);
		no_idle = 1'b1;
		run_phase(500, 8, 15, 1'b0);
		drain_bank();

		// add-heavy over the full pool to keep the table at capacity
		load_run_start(1'b1);
		run_phase(500, KEY_POOL, 50, 1'b0);
		drain_bank();

		load_run_start(1'b0);
		run_phase(450, KEY_POOL, 20, 1'b1);
		drain_bank();

		repeat (SLOTS + 4) @(posedge clk);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
